FILE: hdl/mipsa_pkg.sv
package mipsa_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	// product of one mip without stride is below 2**42, the per-layer sum below 2**43
	localparam int UNIT_W = 42;
	localparam int LU_W = 43;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 15;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int TOT_W = 55;
	localparam int OFF_W = 59;

	localparam logic [2:0] KIND_3D = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_WIDTH   = 3'd0,
		REG_BASE_HEIGHT  = 3'd1,
		REG_BASE_DEPTH   = 3'd2,
		REG_LAYER_COUNT  = 3'd3,
		REG_MIP_COUNT    = 3'd4,
		REG_TEXTURE_KIND = 3'd5,
		REG_PIXEL_FORMAT = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		FMT_R8      = 3'd0,
		FMT_RG8     = 3'd1,
		FMT_RGB8    = 3'd2,
		FMT_RGBA8   = 3'd3,
		FMT_R32F    = 3'd4,
		FMT_RG32F   = 3'd5,
		FMT_RGB32F  = 3'd6,
		FMT_RGBA32F = 3'd7
	} fmt_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MIP   = 2'd1,
		ST_BAD_LAYER = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic [14:0] base_width;
		logic [14:0] base_height;
		logic [11:0] base_depth;
		logic [11:0] layer_count;
		logic [3:0]  mip_count;
		logic [2:0]  texture_kind;
		logic [2:0]  pixel_format;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_IDLE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_CHECK = 4'd2,
		OP_WH    = 4'd3,
		OP_DEP   = 4'd4,
		OP_ACC   = 4'd5,
		OP_LO    = 4'd6,
		OP_HI    = 4'd7,
		OP_SUM   = 4'd8,
		OP_SCALE = 4'd9
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic last_mip;
	} stat_t;

	// strides are 1 or 3 shifted left, so scaling is one add and a shift
	function automatic logic [OFF_W-1:0] scale_stride(input logic [TOT_W-1:0] x,
			input logic [2:0] fmt);
		logic [OFF_W-1:0] v;
		logic [OFF_W-1:0] r;
		v = {{(OFF_W-TOT_W){1'b0}}, x};
		case (fmt)
			FMT_R8:      r = v;
			FMT_RG8:     r = v << 1;
			FMT_RGB8:    r = v + (v << 1);
			FMT_RGBA8:   r = v << 2;
			FMT_R32F:    r = v << 2;
			FMT_RG32F:   r = v << 3;
			FMT_RGB32F:  r = (v + (v << 1)) << 2;
			FMT_RGBA32F: r = v << 4;
			default:     r = v;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/mipsa_cfg.sv
module mipsa_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mipsa_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [mipsa_pkg::CFG_DATA_W-1:0]  wr_data,
	output mipsa_pkg::cfg_t                   cfg
);

	mipsa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_width   <= 15'd1;
			cfg_q.base_height  <= 15'd1;
			cfg_q.base_depth   <= 12'd1;
			cfg_q.layer_count  <= 12'd1;
			cfg_q.mip_count    <= 4'd1;
			cfg_q.texture_kind <= 3'd1;
			cfg_q.pixel_format <= 3'd3;
		end else if (wr_en) begin
			case (wr_index)
				mipsa_pkg::REG_BASE_WIDTH:   cfg_q.base_width   <= wr_data;
				mipsa_pkg::REG_BASE_HEIGHT:  cfg_q.base_height  <= wr_data;
				mipsa_pkg::REG_BASE_DEPTH:   cfg_q.base_depth   <= wr_data[11:0];
				mipsa_pkg::REG_LAYER_COUNT:  cfg_q.layer_count  <= wr_data[11:0];
				mipsa_pkg::REG_MIP_COUNT:    cfg_q.mip_count    <= wr_data[3:0];
				mipsa_pkg::REG_TEXTURE_KIND: cfg_q.texture_kind <= wr_data[2:0];
				mipsa_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/mipsa_dp.sv
module mipsa_dp #(
	parameter int MAX_MIPS = 15,
	parameter int OFFSET_BITS = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mipsa_pkg::cfg_t  cfg,
	input  mipsa_pkg::cmd_t  cmd,
	output mipsa_pkg::stat_t stat,
	input  logic [3:0]       mip_level,
	input  logic [10:0]      layer_index,
	output logic [47:0]      byte_offset,
	output logic [47:0]      byte_size,
	output logic [14:0]      flat_index,
	output logic [1:0]       status
);

	localparam logic [4:0] MAX_M = 5'(MAX_MIPS);

	logic [3:0]  mip_q;
	logic [10:0] layer_q;
	logic [3:0]  m_q;
	logic [1:0]  err_q;
	logic [mipsa_pkg::PROD_W-1:0] prod_q;
	logic [mipsa_pkg::LU_W-1:0]   lu_q;
	logic [mipsa_pkg::LU_W-1:0]   before_q;
	logic [mipsa_pkg::UNIT_W-1:0] size_u_q;
	logic [mipsa_pkg::TOT_W-1:0]  tot_q;
	logic [mipsa_pkg::OFF_W-1:0]  off_q;
	logic [mipsa_pkg::OFF_W-1:0]  size_q;
	logic [14:0] flat_q;

	logic [4:0]  mips;
	logic        bad_mip;
	logic        bad_layer;
	logic [14:0] w_m;
	logic [14:0] h_m;
	logic [11:0] d_m;
	logic [11:0] d_sel;
	logic [mipsa_pkg::MUL_A_W-1:0] mul_a;
	logic [mipsa_pkg::MUL_B_W-1:0] mul_b;
	logic [mipsa_pkg::PROD_W-1:0]  mul_p;
	logic [mipsa_pkg::UNIT_W-1:0]  unit;
	logic [15:0] flat_full;
	logic        ovf;
	logic [1:0]  st;

	assign mips = ({1'b0, cfg.mip_count} < MAX_M) ? {1'b0, cfg.mip_count} : MAX_M;
	assign bad_mip = {1'b0, mip_q} >= mips;
	assign bad_layer = {1'b0, layer_q} >= cfg.layer_count;

	assign stat.bad = bad_mip || bad_layer;
	assign stat.last_mip = {1'b0, m_q} == (mips - 5'd1);

	always_comb begin
		w_m = cfg.base_width >> m_q;
		h_m = cfg.base_height >> m_q;
		d_m = cfg.base_depth >> m_q;
		if (w_m == '0) w_m = 15'd1;
		if (h_m == '0) h_m = 15'd1;
		if (d_m == '0) d_m = 12'd1;
		d_sel = (cfg.texture_kind == mipsa_pkg::KIND_3D) ? d_m : 12'd1;
	end

	// one shared multiplier for the dimension chain and the layer product
	always_comb begin
		case (cmd.op)
			mipsa_pkg::OP_WH: begin
				mul_a = {15'd0, w_m};
				mul_b = h_m;
			end
			mipsa_pkg::OP_DEP: begin
				mul_a = prod_q[mipsa_pkg::MUL_A_W-1:0];
				mul_b = {3'd0, d_sel};
			end
			mipsa_pkg::OP_LO: begin
				mul_a = lu_q[mipsa_pkg::MUL_A_W-1:0];
				mul_b = {4'd0, layer_q};
			end
			mipsa_pkg::OP_HI: begin
				mul_a = {{(mipsa_pkg::MUL_A_W-(mipsa_pkg::LU_W-mipsa_pkg::MUL_A_W)){1'b0}},
					lu_q[mipsa_pkg::LU_W-1:mipsa_pkg::MUL_A_W]};
				mul_b = {4'd0, layer_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {{mipsa_pkg::MUL_B_W{1'b0}}, mul_a} * {{mipsa_pkg::MUL_A_W{1'b0}}, mul_b};
	assign unit = prod_q[mipsa_pkg::UNIT_W-1:0];
	assign flat_full = {5'd0, layer_q} * {12'd0, cfg.mip_count} + {12'd0, mip_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= mipsa_pkg::ST_OK;
			m_q <= '0;
		end else begin
			case (cmd.op)
				mipsa_pkg::OP_LOAD: begin
					m_q <= '0;
				end
				mipsa_pkg::OP_CHECK: begin
					if (bad_mip) err_q <= mipsa_pkg::ST_BAD_MIP;
					else if (bad_layer) err_q <= mipsa_pkg::ST_BAD_LAYER;
					else err_q <= mipsa_pkg::ST_OK;
				end
				mipsa_pkg::OP_DEP: begin
					m_q <= m_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// prod_q holds the unit size of mip m_q-1 when it is accumulated
	always_ff @(posedge clk) begin
		case (cmd.op)
			mipsa_pkg::OP_LOAD: begin
				mip_q <= mip_level;
				layer_q <= layer_index;
				lu_q <= '0;
				before_q <= '0;
				size_u_q <= '0;
			end
			mipsa_pkg::OP_WH, mipsa_pkg::OP_ACC: begin
				if (cmd.op == mipsa_pkg::OP_ACC || m_q != '0) begin
					lu_q <= lu_q + {1'b0, unit};
					if (m_q <= mip_q) before_q <= before_q + {1'b0, unit};
					if ({1'b0, m_q} == {1'b0, mip_q} + 5'd1) size_u_q <= unit;
				end
				if (cmd.op == mipsa_pkg::OP_WH) prod_q <= mul_p;
			end
			mipsa_pkg::OP_DEP, mipsa_pkg::OP_LO: begin
				prod_q <= mul_p;
			end
			mipsa_pkg::OP_HI: begin
				tot_q <= {{(mipsa_pkg::TOT_W-mipsa_pkg::LU_W){1'b0}}, before_q}
					+ {{(mipsa_pkg::TOT_W-mipsa_pkg::PROD_W){1'b0}}, prod_q};
				prod_q <= mul_p;
			end
			mipsa_pkg::OP_SUM: begin
				tot_q <= tot_q + (mipsa_pkg::TOT_W'(prod_q) << mipsa_pkg::MUL_A_W);
			end
			mipsa_pkg::OP_SCALE: begin
				off_q <= mipsa_pkg::scale_stride(tot_q, cfg.pixel_format);
				size_q <= mipsa_pkg::scale_stride(
					{{(mipsa_pkg::TOT_W-mipsa_pkg::UNIT_W){1'b0}}, size_u_q}, cfg.pixel_format);
				flat_q <= flat_full[14:0];
			end
			default: ;
		endcase
	end

	assign ovf = (off_q >> OFFSET_BITS) != '0;
	assign st = (err_q != mipsa_pkg::ST_OK) ? err_q :
		(ovf ? mipsa_pkg::ST_OVERFLOW : mipsa_pkg::ST_OK);

	assign status = st;
	assign byte_offset = (st == mipsa_pkg::ST_OK) ? off_q[47:0] : '0;
	assign byte_size = (st == mipsa_pkg::ST_OK) ? size_q[47:0] : '0;
	assign flat_index = (st == mipsa_pkg::ST_OK) ? flat_q : '0;

endmodule

FILE: hdl/mipsa_ctrl.sv
module mipsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mipsa_pkg::stat_t stat,
	output mipsa_pkg::cmd_t  cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CHECK = 10'b0000000010,
		S_WH    = 10'b0000000100,
		S_DEP   = 10'b0000001000,
		S_ACC   = 10'b0000010000,
		S_LO    = 10'b0000100000,
		S_HI    = 10'b0001000000,
		S_SUM   = 10'b0010000000,
		S_SCALE = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = mipsa_pkg::OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = mipsa_pkg::OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.op = mipsa_pkg::OP_CHECK;
				state_d = stat.bad ? S_DONE : S_WH;
			end
			S_WH: begin
				cmd.op = mipsa_pkg::OP_WH;
				state_d = S_DEP;
			end
			S_DEP: begin
				cmd.op = mipsa_pkg::OP_DEP;
				state_d = stat.last_mip ? S_ACC : S_WH;
			end
			S_ACC: begin
				cmd.op = mipsa_pkg::OP_ACC;
				state_d = S_LO;
			end
			S_LO: begin
				cmd.op = mipsa_pkg::OP_LO;
				state_d = S_HI;
			end
			S_HI: begin
				cmd.op = mipsa_pkg::OP_HI;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.op = mipsa_pkg::OP_SUM;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.op = mipsa_pkg::OP_SCALE;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule

FILE: hdl/mip_subresource_address.sv
// after the accepting edge the controller runs CHECK, then WH and DEP for each of the
// M = min(mip_count, MAX_MIPS) mip levels (two passes of the shared multiplier per level),
// then ACC, LO and HI (two passes for the layer product), SUM, SCALE and DONE; an out-of-range
// mip or layer goes from CHECK to DONE. A new transaction is taken only back in idle after DONE
// reset: arst_n clears the controller to idle and the config, status and mip counter registers
// the receiver cannot stall: done is high for one cycle, and the result holds until the next check
module mip_subresource_address #(
	parameter int MAX_MIPS = 15,
	parameter int OFFSET_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mipsa_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [mipsa_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [3:0]                        mip_level,
	input  logic [10:0]                       layer_index,
	output logic                              done,
	output logic [47:0]                       byte_offset,
	output logic [47:0]                       byte_size,
	output logic [14:0]                       flat_index,
	output logic [1:0]                        status
);

	mipsa_pkg::cfg_t  cfg;
	mipsa_pkg::cmd_t  cmd;
	mipsa_pkg::stat_t stat;

	mipsa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	mipsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mipsa_dp #(
		.MAX_MIPS    (MAX_MIPS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.mip_level   (mip_level),
		.layer_index (layer_index),
		.byte_offset (byte_offset),
		.byte_size   (byte_size),
		.flat_index  (flat_index),
		.status      (status)
	);

endmodule

FILE: dv/mip_subresource_address_checker.sv
module mip_subresource_address_checker
	import mipsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  start,
	input  logic                  busy,
	input  logic [3:0]            mip_level,
	input  logic [10:0]           layer_index,
	input  logic                  done,
	input  logic [47:0]           byte_offset,
	input  logic [47:0]           byte_size,
	input  logic [14:0]           flat_index,
	input  logic [1:0]            status,
	input  logic                  flush,
	output int                    errors,
	output int                    outstanding
);

	localparam int MAX_MIPS = 15;
	localparam logic [63:0] OFFSET_MAX = (64'd1 << 48) - 64'd1;

	typedef struct {
		logic [47:0] byte_offset;
		logic [47:0] byte_size;
		logic [14:0] flat_index;
		status_t     status;
	} subres_t;

	cfg_t    regs;
	subres_t subres_q[$];
	subres_t want;

	function automatic logic [63:0] stride_of(input logic [2:0] fmt);
		case (fmt)
			FMT_R8:      return 64'd1;
			FMT_RG8:     return 64'd2;
			FMT_RGB8:    return 64'd3;
			FMT_RGBA8:   return 64'd4;
			FMT_R32F:    return 64'd4;
			FMT_RG32F:   return 64'd8;
			FMT_RGB32F:  return 64'd12;
			FMT_RGBA32F: return 64'd16;
			default:     return 64'd0;
		endcase
	endfunction

	// a dimension never shrinks below one pixel
	function automatic logic [63:0] dim_at(input logic [63:0] base, input logic [3:0] m);
		logic [63:0] v;
		v = base >> m;
		return (v == 64'd0) ? 64'd1 : v;
	endfunction

	function automatic logic [63:0] level_bytes(input logic [3:0] m);
		logic [63:0] d;
		d = (regs.texture_kind == KIND_3D) ? dim_at(64'(regs.base_depth), m) : 64'd1;
		return dim_at(64'(regs.base_width), m) * dim_at(64'(regs.base_height), m) * d *
			stride_of(regs.pixel_format);
	endfunction

	function automatic subres_t predict_subres(input logic [3:0] mip, input logic [10:0] layer);
		subres_t     r;
		logic [63:0] mips;
		logic [63:0] per_layer;
		logic [63:0] ahead;
		logic [63:0] offset;
		logic [31:0] flat;
		int          m;
		r.byte_offset = '0;
		r.byte_size = '0;
		r.flat_index = '0;
		r.status = ST_OK;
		mips = (regs.mip_count < MAX_MIPS) ? 64'(regs.mip_count) : 64'(MAX_MIPS);
		// the mip test wins over the layer test
		if (64'(mip) >= mips) begin
			r.status = ST_BAD_MIP;
			return r;
		end
		if (12'(layer) >= regs.layer_count) begin
			r.status = ST_BAD_LAYER;
			return r;
		end
		per_layer = '0;
		ahead = '0;
		for (m = 0; m < int'(mips); m++) begin
			if (m < int'(mip))
				ahead = ahead + level_bytes(4'(m));
			per_layer = per_layer + level_bytes(4'(m));
		end
		offset = 64'(layer) * per_layer + ahead;
		if (offset > OFFSET_MAX) begin
			r.status = ST_OVERFLOW;
			return r;
		end
		flat = 32'(layer) * 32'(regs.mip_count) + 32'(mip);
		r.byte_offset = offset[47:0];
		r.byte_size = 48'(level_bytes(mip));
		r.flat_index = flat[14:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
		$display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, exp_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.base_width = 15'd1;
			regs.base_height = 15'd1;
			regs.base_depth = 12'd1;
			regs.layer_count = 12'd1;
			regs.mip_count = 4'd1;
			regs.texture_kind = 3'd1;
			regs.pixel_format = FMT_RGBA8;
			subres_q.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_BASE_WIDTH:   regs.base_width = wr_data[14:0];
					REG_BASE_HEIGHT:  regs.base_height = wr_data[14:0];
					REG_BASE_DEPTH:   regs.base_depth = wr_data[11:0];
					REG_LAYER_COUNT:  regs.layer_count = wr_data[11:0];
					REG_MIP_COUNT:    regs.mip_count = wr_data[3:0];
					REG_TEXTURE_KIND: regs.texture_kind = wr_data[2:0];
					REG_PIXEL_FORMAT: regs.pixel_format = wr_data[2:0];
					default: ;
				endcase
			end
			if (start && !busy)
				subres_q.push_back(predict_subres(mip_level, layer_index));
			if (done) begin
				if (subres_q.size() == 0) begin
					report("result with no transaction waiting", 64'(status), 64'd0);
				end else begin
					want = subres_q.pop_front();
					if (byte_offset !== want.byte_offset)
						report("byte_offset", 64'(byte_offset), 64'(want.byte_offset));
					if (byte_size !== want.byte_size)
						report("byte_size", 64'(byte_size), 64'(want.byte_size));
					if (flat_index !== want.flat_index)
						report("flat_index", 64'(flat_index), 64'(want.flat_index));
					if (status !== want.status)
						report("status", 64'(status), 64'(want.status));
				end
			end
			if (flush && subres_q.size() != 0) begin
				report("transactions never answered", 64'(subres_q.size()), 64'd0);
				subres_q.delete();
			end
			outstanding <= subres_q.size();
		end
	end

endmodule

FILE: dv/mip_subresource_address_tb.sv
module mip_subresource_address_tb;
	import mipsa_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 48;
	localparam int RANDOM_PHASES = 24;
	localparam int ITEMS_PER_PHASE = 77;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [3:0]            mip_level = '0;
	logic [10:0]           layer_index = '0;
	logic                  done;
	logic [47:0]           byte_offset;
	logic [47:0]           byte_size;
	logic [14:0]           flat_index;
	logic [1:0]            status;
	logic                  flush = 1'b0;
	int                    errors;
	int                    outstanding;
	int                    stall_cycles = 0;
	int                    idle_pct = 30;
	cfg_t                  cur_cfg;

	mip_subresource_address dut (.*);

	mip_subresource_address_checker checker_i (.*);

	always #5 clk = ~clk;

	// no transaction for too long means the block hung
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("mip_subresource_address_tb: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
	endtask

	// unused upper data bits carry junk, the block must mask them
	task automatic load_config(input cfg_t c);
		write_reg(REG_BASE_WIDTH, c.base_width);
		write_reg(REG_BASE_HEIGHT, c.base_height);
		write_reg(REG_BASE_DEPTH, {3'($urandom), c.base_depth});
		write_reg(REG_LAYER_COUNT, {3'($urandom), c.layer_count});
		write_reg(REG_MIP_COUNT, {11'($urandom), c.mip_count});
		write_reg(REG_TEXTURE_KIND, {12'($urandom), c.texture_kind});
		write_reg(REG_PIXEL_FORMAT, {12'($urandom), c.pixel_format});
		write_reg(REG_UNMAPPED, 15'($urandom));
		@(posedge clk);
		wr_en <= 1'b0;
		cur_cfg = c;
	endtask

	// returns at the accepting edge with start still high
	task automatic send_item(input logic [3:0] m, input logic [10:0] l);
		start <= 1'b1;
		mip_level <= m;
		layer_index <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		mip_level <= 4'($urandom);
		layer_index <= 11'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy);
	endtask

	function automatic cfg_t pick_config(input bit wild);
		cfg_t c;
		if (wild) begin
			c.base_width = 15'($urandom);
			c.base_height = 15'($urandom);
			c.base_depth = 12'($urandom);
			c.layer_count = 12'($urandom);
			c.mip_count = 4'($urandom);
			c.texture_kind = 3'($urandom);
			c.pixel_format = 3'($urandom);
		end else begin
			c.base_width = ($urandom_range(1) != 0) ? 15'(1 << $urandom_range(0, 14)) :
				15'($urandom_range(1, 16384));
			c.base_height = ($urandom_range(1) != 0) ? 15'(1 << $urandom_range(0, 14)) :
				15'($urandom_range(1, 16384));
			c.base_depth = ($urandom_range(1) != 0) ? 12'(1 << $urandom_range(0, 11)) :
				12'($urandom_range(1, 2048));
			c.layer_count = ($urandom_range(1) != 0) ? 12'($urandom_range(1, 2048)) :
				12'($urandom_range(1, 8));
			c.mip_count = 4'($urandom_range(1, 15));
			c.texture_kind = ($urandom_range(9) != 0) ? 3'($urandom_range(0, 4)) :
				3'($urandom_range(5, 7));
			c.pixel_format = 3'($urandom_range(0, 7));
		end
		return c;
	endfunction

	// mostly in-range requests, the rest anywhere in the field
	task automatic random_request();
		logic [3:0]  m;
		logic [10:0] l;
		int          mips;
		int          layers;
		mips = cur_cfg.mip_count;
		layers = (cur_cfg.layer_count > 2048) ? 2048 : cur_cfg.layer_count;
		if ($urandom_range(99) < 80 && mips != 0 && layers != 0) begin
			m = 4'($urandom_range(mips - 1));
			l = 11'($urandom_range(layers - 1));
		end else begin
			m = 4'($urandom);
			l = 11'($urandom);
		end
		send_item(m, l);
		if ($urandom_range(99) < idle_pct)
			idle_for($urandom_range(1, 2 * mips + 10));
	endtask

	initial begin
		cfg_t c;
		int   phase;
		int   n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		cur_cfg = '{base_width: 15'd1, base_height: 15'd1, base_depth: 12'd1,
			layer_count: 12'd1, mip_count: 4'd1, texture_kind: 3'd1, pixel_format: FMT_RGBA8};
		@(posedge clk);

		// settings after reset, bad mip takes priority over bad layer
		send_item(4'd0, 11'd0);
		send_item(4'd1, 11'd0);
		send_item(4'd0, 11'd1);
		send_item(4'd15, 11'd2047);
		drain();

		// largest legal 3d texture, far layers overflow the offset
		c = '{base_width: 15'd16384, base_height: 15'd16384, base_depth: 12'd2048,
			layer_count: 12'd2048, mip_count: 4'd15, texture_kind: KIND_3D,
			pixel_format: FMT_RGBA32F};
		load_config(c);
		send_item(4'd0, 11'd0);
		send_item(4'd14, 11'd0);
		send_item(4'd7, 11'd1);
		send_item(4'd0, 11'd2047);
		send_item(4'd14, 11'd2047);
		send_item(4'd15, 11'd0);
		drain();

		// every register bit set but the pixel format, unused kind acts as flat
		c = '{base_width: 15'h7fff, base_height: 15'h7fff, base_depth: 12'hfff,
			layer_count: 12'hfff, mip_count: 4'd15, texture_kind: 3'd7,
			pixel_format: FMT_RGB8};
		load_config(c);
		send_item(4'd3, 11'd2047);
		send_item(4'd14, 11'd1);
		send_item(4'd0, 11'd0);
		drain();

		// zero mip count, then zero layer count
		c = '{base_width: 15'd0, base_height: 15'd0, base_depth: 12'd0,
			layer_count: 12'd0, mip_count: 4'd0, texture_kind: 3'd0,
			pixel_format: FMT_R8};
		load_config(c);
		send_item(4'd0, 11'd0);
		drain();
		c.mip_count = 4'd4;
		load_config(c);
		send_item(4'd2, 11'd0);
		drain();

		// zero dimensions count as one pixel
		c = '{base_width: 15'd0, base_height: 15'd0, base_depth: 12'd0,
			layer_count: 12'd3, mip_count: 4'd15, texture_kind: KIND_3D,
			pixel_format: FMT_RGB32F};
		load_config(c);
		send_item(4'd0, 11'd2);
		send_item(4'd14, 11'd1);
		drain();

		c = '{base_width: 15'd256, base_height: 15'd1, base_depth: 12'd1,
			layer_count: 12'd6, mip_count: 4'd9, texture_kind: 3'd3,
			pixel_format: FMT_RG8};
		load_config(c);
		send_item(4'd8, 11'd5);
		send_item(4'd0, 11'd3);
		drain();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_pct = (phase == 1) ? 0 : 30;
			load_config(pick_config(phase % 6 == 5));
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				random_request();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		flush <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (errors == 0)
			$display("mip_subresource_address_tb: clean");
		else
			$display("mip_subresource_address_tb: errors");
		$finish;
	end

endmodule
